/* rtl/core/itoa_pkg.sv */
// Types and constants for the signed integer to decimal text converter.
`default_nettype none

package itoa_pkg;

    localparam int VALUE_W   = 32;
    localparam int CHAR_W    = 6;
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W     = 4 * NUM_DIGITS;
    localparam int BIT_CNT_W = $clog2(VALUE_W);
    localparam int DIG_CNT_W = $clog2(NUM_DIGITS + 1);

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_EMIT
    } itoa_state_t;

endpackage : itoa_pkg

`default_nettype wire

/* rtl/core/signed_int_to_decimal_ascii.sv */
// Top level: signed 32-bit integer to decimal ASCII text, bit-serial double dabble.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------
//  input    | start & !busy          | value[31:0] (signed)
//  result   | strobe (one cycle)     | char_code[5:0], last
//
//  A transaction is taken when start is high and busy is low. A negative value
//  gives '-' on the cycle after acceptance. The magnitude is then shifted one
//  bit per cycle through the BCD digit register, and the ten digits leave four
//  bits per cycle: leading zeros are dropped one per cycle, the rest emitted
//  one per cycle. busy is low again in the cycle that shows the last character.
//  Reset returns the block to idle and drops strobe; there is no back-pressure
//  on results.
`default_nettype none

module signed_int_to_decimal_ascii (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic signed [itoa_pkg::VALUE_W-1:0] value,
    output logic                              strobe,
    output logic [itoa_pkg::CHAR_W-1:0]       char_code,
    output logic                              last
);
    import itoa_pkg::*;

    itoa_state_t               state_reg, state_next;
    logic [VALUE_W-1:0]        mag_reg, mag_next;
    logic [BCD_W-1:0]          bcd_reg, bcd_next;
    logic [BIT_CNT_W-1:0]      bit_cnt_reg, bit_cnt_next;
    logic [DIG_CNT_W-1:0]      dig_cnt_reg, dig_cnt_next;
    logic                      strobe_reg, strobe_next;
    logic [CHAR_W-1:0]         char_reg, char_next;
    logic                      last_reg, last_next;

    logic [BCD_W-1:0]          bcd_adj;
    logic [3:0]                top_digit;
    logic                      accept;
    logic                      final_digit;

    assign accept      = start && (state_reg == ST_IDLE);
    assign top_digit   = bcd_reg[BCD_W-1 -: 4];
    assign final_digit = (dig_cnt_reg == DIG_CNT_W'(1));

    // add-3 correction on each BCD digit before the shift
    always_comb
    begin
        for (int d = 0; d < NUM_DIGITS; d++)
        begin
            if (bcd_reg[4*d +: 4] >= 4'd5)
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4] + 4'd3;
            else
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_CONV;
            end
            ST_CONV:
            begin
                if (bit_cnt_reg == BIT_CNT_W'(VALUE_W - 1))
                    state_next = ST_SKIP;
            end
            ST_SKIP:
            begin
                if (final_digit)
                    state_next = ST_IDLE;
                else if (top_digit != 4'd0)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (final_digit)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath and result registers
    always_comb
    begin
        mag_next     = mag_reg;
        bcd_next     = bcd_reg;
        bit_cnt_next = bit_cnt_reg;
        dig_cnt_next = dig_cnt_reg;
        strobe_next  = 1'b0;
        char_next    = char_reg;
        last_next    = last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    mag_next     = value[VALUE_W-1] ? (~value) + VALUE_W'(1) : value;
                    bcd_next     = '0;
                    bit_cnt_next = '0;
                    dig_cnt_next = DIG_CNT_W'(NUM_DIGITS);
                    if (value[VALUE_W-1])
                    begin
                        strobe_next = 1'b1;
                        char_next   = CHAR_MINUS;
                        last_next   = 1'b0;
                    end
                end
            end
            ST_CONV:
            begin
                bcd_next     = {bcd_adj[BCD_W-2:0], mag_reg[VALUE_W-1]};
                mag_next     = {mag_reg[VALUE_W-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + BIT_CNT_W'(1);
            end
            ST_SKIP, ST_EMIT:
            begin
                bcd_next     = {bcd_reg[BCD_W-5:0], 4'd0};
                dig_cnt_next = dig_cnt_reg - DIG_CNT_W'(1);
                if (state_reg == ST_EMIT || top_digit != 4'd0 || final_digit)
                begin
                    strobe_next = 1'b1;
                    char_next   = CHAR_ZERO + {2'b00, top_digit};
                    last_next   = final_digit;
                end
            end
            default:
            begin
                strobe_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            bit_cnt_reg <= '0;
            dig_cnt_reg <= '0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            bit_cnt_reg <= bit_cnt_next;
            dig_cnt_reg <= dig_cnt_next;
            strobe_reg  <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        bcd_reg  <= bcd_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign busy      = (state_reg != ST_IDLE);
    assign strobe    = strobe_reg;
    assign char_code = char_reg;
    assign last      = last_reg;

endmodule : signed_int_to_decimal_ascii

`default_nettype wire
